// ===== hdl/rau_pkg.sv =====
// Package with shared widths, operation codes and queue entry type for the rational unit.
package rau_pkg;

   localparam int unsigned OPERAND_WIDTH_DEF = 32;
   localparam int unsigned RES_NUM_W = 64;
   localparam int unsigned RES_DEN_W = 62;
   localparam int unsigned MAG_W = 64;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   // One unreduced problem handed from the front part to the back part.
   typedef struct packed {
      logic             zero;
      logic             neg;
      logic [MAG_W-1:0] mag_num;
      logic [MAG_W-1:0] mag_den;
   } job_type;

endpackage

// ===== hdl/rational_arithmetic_unit_core.sv =====
// Top level of the rational arithmetic unit: front part, job queue and reducing back part.
//
//  channel  | direction | handshake              | payload
//  request  | in        | start, busy            | req_kind, req_a_num, req_a_den,
//           |           |                        | req_b_num, req_b_den
//  response | out       | rsp_strobe (one cycle) | rsp_res_num, rsp_res_den
//
// The front part takes a new transaction only when idle; it registers the products,
// then the sum and sign, and holds the job until the queue has room. The back part runs
// a binary gcd (one step per cycle) and then two restoring divisions by the gcd; it takes
// a new job only when idle. A zero result skips the loops and goes to the output state.
// Reset clears the state machines and the queue. The receiver cannot stall the unit.
module rational_arithmetic_unit_core
   import rau_pkg::*;
#(
   parameter int unsigned OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_kind,
   input  logic [OPERAND_WIDTH-1:0] req_a_num,
   input  logic [OPERAND_WIDTH-2:0] req_a_den,
   input  logic [OPERAND_WIDTH-1:0] req_b_num,
   input  logic [OPERAND_WIDTH-2:0] req_b_den,
   output logic                     rsp_strobe,
   output logic [RES_NUM_W-1:0]     rsp_res_num,
   output logic [RES_DEN_W-1:0]     rsp_res_den
);

   logic    f_valid, q_not_full, q_not_empty, b_pop;
   job_type f_job, q_job;

   rau_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_a_num(req_a_num), .req_a_den(req_a_den),
      .req_b_num(req_b_num), .req_b_den(req_b_den),
      .job_valid(f_valid), .job(f_job), .job_ready(q_not_full)
   );

   rau_queue u_queue (
      .clock(clock), .reset(reset),
      .push(f_valid), .push_data(f_job), .not_full(q_not_full),
      .pop(b_pop), .not_empty(q_not_empty), .pop_data(q_job)
   );

   rau_back u_back (
      .clock(clock), .reset(reset),
      .job_valid(q_not_empty), .job(q_job), .job_pop(b_pop),
      .rsp_strobe(rsp_strobe), .rsp_res_num(rsp_res_num), .rsp_res_den(rsp_res_den)
   );

endmodule

// ===== hdl/rau_front.sv =====
// Front part: takes an operation, forms the exact cross products and pushes the job to the queue.
module rau_front
   import rau_pkg::*;
#(
   parameter int unsigned OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_kind,
   input  logic [OPERAND_WIDTH-1:0] req_a_num,
   input  logic [OPERAND_WIDTH-2:0] req_a_den,
   input  logic [OPERAND_WIDTH-1:0] req_b_num,
   input  logic [OPERAND_WIDTH-2:0] req_b_den,
   output logic                     job_valid,
   output job_type                  job,
   input  logic                     job_ready
);

   localparam int unsigned W = OPERAND_WIDTH;
   localparam int unsigned PW = 2 * W;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_SUM  = 4'b0100,
      ST_PUSH = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   op_type kind_ff;
   logic signed [W:0] an_ff, bn_ff, ad_ff, bd_ff;
   logic signed [PW+1:0] p1_ff, p2_ff, p3_ff, p1_in, p2_in, p3_in;
   job_type job_ff, job_in;

   logic signed [PW+1:0] rn, rd;
   logic [PW+1:0] mn, md;

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (start) state_in = ST_MUL;
         ST_MUL:  state_in = ST_SUM;
         ST_SUM:  state_in = ST_PUSH;
         ST_PUSH: if (job_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // One product per multiplier; a zero denominator turns the operand into 0/1.
   // Operands are sign-extended first so that each product is exact.
   always_comb begin
      p1_in = '0;
      p2_in = '0;
      p3_in = '0;
      unique case (kind_ff)
         OP_ADD, OP_SUB: begin
            p1_in = (PW+2)'(an_ff) * (PW+2)'(bd_ff);
            p2_in = (PW+2)'(ad_ff) * (PW+2)'(bn_ff);
            p3_in = (PW+2)'(ad_ff) * (PW+2)'(bd_ff);
         end
         OP_MUL: begin
            p1_in = (PW+2)'(an_ff) * (PW+2)'(bn_ff);
            p3_in = (PW+2)'(ad_ff) * (PW+2)'(bd_ff);
         end
         OP_DIV: begin
            p1_in = (PW+2)'(an_ff) * (PW+2)'(bd_ff);
            p3_in = (PW+2)'(ad_ff) * (PW+2)'(bn_ff);
         end
         default: ;
      endcase
   end

   always_comb begin
      unique case (kind_ff)
         OP_ADD:  rn = p1_ff + p2_ff;
         OP_SUB:  rn = p1_ff - p2_ff;
         default: rn = p1_ff;
      endcase
      rd = p3_ff;
      mn = rn[PW+1] ? -rn : rn;
      md = rd[PW+1] ? -rd : rd;
      job_in.zero    = (rn == '0) || (rd == '0);
      job_in.neg     = rn[PW+1] ^ rd[PW+1];
      job_in.mag_num = MAG_W'(mn);
      job_in.mag_den = MAG_W'(md);
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         kind_ff <= op_type'(req_kind);
         if (req_a_den == '0) begin
            an_ff <= '0;
            ad_ff <= (W+1)'(1);
         end else begin
            an_ff <= {req_a_num[W-1], req_a_num};
            ad_ff <= {2'b00, req_a_den};
         end
         if (req_b_den == '0) begin
            bn_ff <= '0;
            bd_ff <= (W+1)'(1);
         end else begin
            bn_ff <= {req_b_num[W-1], req_b_num};
            bd_ff <= {2'b00, req_b_den};
         end
      end
      if (state_ff == ST_MUL) begin
         p1_ff <= p1_in;
         p2_ff <= p2_in;
         p3_ff <= p3_in;
      end
      if (state_ff == ST_SUM) begin
         job_ff <= job_in;
      end
   end

   assign job_valid = (state_ff == ST_PUSH);
   assign job = job_ff;

endmodule

// ===== hdl/rau_queue.sv =====
// Two-entry queue between the front and back parts.
module rau_queue
   import rau_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   output logic    not_full,
   input  logic    pop,
   output logic    not_empty,
   output job_type pop_data
);

   job_type mem_ff [2];
   logic wptr_ff, rptr_ff;
   logic [1:0] count_ff;

   assign not_full  = (count_ff != 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_data  = mem_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push && not_full) wptr_ff <= ~wptr_ff;
         if (pop && not_empty) rptr_ff <= ~rptr_ff;
         count_ff <= count_ff + 2'((push && not_full) ? 1 : 0)
                     - 2'((pop && not_empty) ? 1 : 0);
      end
   end

   always_ff @(posedge clock) begin
      if (push && not_full) mem_ff[wptr_ff] <= push_data;
   end

endmodule

// ===== hdl/rau_back.sv =====
// Back part: binary gcd and restoring division, one step per cycle on a shared datapath.
module rau_back
   import rau_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   input  job_type              job,
   output logic                 job_pop,
   output logic                 rsp_strobe,
   output logic [RES_NUM_W-1:0] rsp_res_num,
   output logic [RES_DEN_W-1:0] rsp_res_den
);

   localparam int unsigned CW = $clog2(MAG_W + 1);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_GCD   = 5'b00010,
      ST_DIVN  = 5'b00100,
      ST_DIVD  = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [MAG_W-1:0] x_ff, y_ff, num_ff, den_ff, g_ff;
   logic [MAG_W-1:0] q_ff, qn_ff;
   logic [MAG_W:0]   r_ff;
   logic [CW-1:0]    cnt_ff, sh_ff;
   logic             neg_ff, zero_ff;
   logic [RES_NUM_W-1:0] out_num_ff;
   logic [RES_DEN_W-1:0] out_den_ff;

   logic [MAG_W-1:0] dividend;
   logic [MAG_W:0]   r_sh, r_sub;
   logic [MAG_W-1:0] diff;

   assign job_pop = (state_ff == ST_IDLE) && job_valid;

   // When both values are odd, the larger is replaced by half their difference.
   assign diff = (x_ff > y_ff) ? (x_ff - y_ff) : (y_ff - x_ff);

   assign dividend = (state_ff == ST_DIVN) ? num_ff : den_ff;
   assign r_sh  = {r_ff[MAG_W-1:0], dividend[cnt_ff[CW-2:0]]};
   assign r_sub = r_sh - {1'b0, g_ff};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (job_valid) state_in = job.zero ? ST_OUT : ST_GCD;
         ST_GCD:  if (x_ff == y_ff) state_in = ST_DIVN;
         ST_DIVN: if (cnt_ff == '0) state_in = ST_DIVD;
         ST_DIVD: if (cnt_ff == '0) state_in = ST_OUT;
         ST_OUT:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            x_ff    <= job.mag_num;
            y_ff    <= job.mag_den;
            num_ff  <= job.mag_num;
            den_ff  <= job.mag_den;
            neg_ff  <= job.neg;
            zero_ff <= job.zero;
            sh_ff   <= '0;
         end
         ST_GCD: begin
            // Common factors of two are counted and put back once the odd parts agree.
            if (x_ff != y_ff) begin
               priority if (!x_ff[0] && !y_ff[0]) begin
                  x_ff  <= x_ff >> 1;
                  y_ff  <= y_ff >> 1;
                  sh_ff <= sh_ff + CW'(1);
               end else if (!x_ff[0]) begin
                  x_ff <= x_ff >> 1;
               end else if (!y_ff[0]) begin
                  y_ff <= y_ff >> 1;
               end else if (x_ff > y_ff) begin
                  x_ff <= diff >> 1;
               end else begin
                  y_ff <= diff >> 1;
               end
            end
            g_ff   <= x_ff << sh_ff;
            r_ff   <= '0;
            cnt_ff <= CW'(MAG_W - 1);
         end
         ST_DIVN, ST_DIVD: begin
            if (!r_sub[MAG_W]) begin
               r_ff <= r_sub;
               q_ff <= {q_ff[MAG_W-2:0], 1'b1};
            end else begin
               r_ff <= r_sh;
               q_ff <= {q_ff[MAG_W-2:0], 1'b0};
            end
            if (cnt_ff == '0) begin
               cnt_ff <= CW'(MAG_W - 1);
               r_ff   <= '0;
               if (state_ff == ST_DIVN) qn_ff <= {q_ff[MAG_W-2:0], ~r_sub[MAG_W]};
            end else begin
               cnt_ff <= cnt_ff - CW'(1);
            end
         end
         ST_OUT: ;
         default: ;
      endcase
      if (state_ff == ST_DIVD && cnt_ff == '0) begin
         out_num_ff <= neg_ff ? -qn_ff : qn_ff;
         out_den_ff <= RES_DEN_W'({q_ff[MAG_W-2:0], ~r_sub[MAG_W]});
      end else if (state_ff == ST_IDLE && job_valid && job.zero) begin
         out_num_ff <= '0;
         out_den_ff <= RES_DEN_W'(1);
      end
   end

   assign rsp_strobe  = (state_ff == ST_OUT);
   assign rsp_res_num = out_num_ff;
   assign rsp_res_den = out_den_ff;

endmodule

// ===== hdl/rau_checker.sv =====
// Port-level checker for the rational arithmetic unit and its bind statement.
module rau_checker
   import rau_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_strobe,
   input logic [RES_NUM_W-1:0] rsp_res_num,
   input logic [RES_DEN_W-1:0] rsp_res_den
);

   // An accepted transaction makes the unit busy in the next cycle.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("busy not raised");

   // A response never shows a zero denominator.
   a_den: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_res_den != '0)) else $error("zero denominator");

   // A zero numerator always comes with denominator one.
   a_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_res_num == '0) |-> (rsp_res_den == RES_DEN_W'(1)))
      else $error("zero not reduced");

   // Responses are single-cycle strobes.
   a_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("strobe held");

endmodule

bind rational_arithmetic_unit_core rau_checker u_rau_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_strobe(rsp_strobe), .rsp_res_num(rsp_res_num), .rsp_res_den(rsp_res_den)
);
